[sv/depth_pixel_backprojection_unit_assert.svh]
// Assertion macros for the depth pixel back-projection unit.
// Each macro expects signals named clk and rst in the including scope.
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define DPBU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define DPBU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

[sv/dpbu_pkg.sv]
// Shared types, constants and helper functions of the back-projection unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package dpbu_pkg;

  // Width of the shared restoring divider (dividend and quotient).
  localparam int DIV_W  = 48;
  localparam int STEP_W = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] POS_LIM = 48'h007F_FFFF_FFFF;
  localparam logic [DIV_W-1:0] NEG_LIM = 48'h0080_0000_0000;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_FOCAL_X      = 3'd4,
    CFG_FOCAL_Y      = 3'd5,
    CFG_DEPTH_SCALE  = 3'd6
  } cfg_idx_t;

  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [15:0] RST_CENTER_X     = 16'd5120;
  localparam logic [15:0] RST_CENTER_Y     = 16'd3840;
  localparam logic [15:0] RST_FOCAL_X      = 16'd8400;
  localparam logic [15:0] RST_FOCAL_Y      = 16'd8400;
  localparam logic [15:0] RST_DEPTH_SCALE  = 16'd1000;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [15:0] depth_scale;
  } cfg_t;

  // One classified pixel waiting for the back end.
  typedef struct packed {
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] dx_mag;
    logic        dx_neg;
    logic [15:0] dy_mag;
    logic        dy_neg;
    logic        has_point;
    logic        frame_end;
    logic [24:0] point_count;
  } item_t;

  typedef struct packed {
    logic [39:0] pos_x;
    logic [39:0] pos_y;
    logic [31:0] pos_z;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic        has_point;
    logic        frame_end;
    logic [24:0] point_count;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ZDIV,
    BK_XMUL,
    BK_XDIV,
    BK_YMUL,
    BK_YDIV,
    BK_DONE
  } back_state_t;

  // Apply the sign to a quotient magnitude and saturate to 40 bits.
  function automatic logic [39:0] sat_coord(input logic [DIV_W-1:0] q, input logic neg);
    logic [DIV_W-1:0] m;
    if (neg) begin
      m = (q > NEG_LIM) ? NEG_LIM : q;
      sat_coord = 40'((~m) + 48'd1);
    end else begin
      m = (q > POS_LIM) ? POS_LIM : q;
      sat_coord = 40'(m);
    end
  endfunction

endpackage

`default_nettype wire

[sv/depth_pixel_backprojection_unit.sv]
// Depth pixel back-projection unit, top level. A pixel with depth makes three
// passes through the shared 48-step divider (z, then x, then y) before its result
// is ready; a frame-end pixel with no depth skips the divider. The back end
// works on one point at a time; zero-depth pixels that end no frame
// are taken one per cycle while the queue has room. Synchronous active-high reset
// clears counters, queue and sequencer and restores the register defaults.
`default_nettype none

module depth_pixel_backprojection_unit import dpbu_pkg::*; #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Pixel stream in.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [39:0]  s_tdata,    // depth[15:0], blue[23:16], green[31:24], red[39:32]
  // Point stream out.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [167:0]      m_tdata,    // pos_x[39:0], pos_y[79:40], pos_z[111:80],
                                        // out_blue[119:112], out_green[127:120],
                                        // out_red[135:128], point_count[160:136], zeros
  output logic [0:0]        m_tuser,    // has_point
  output logic              m_tlast,    // frame_end
  // Configuration write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  `include "depth_pixel_backprojection_unit_assert.svh"

  // Register file. The user must make writes only while the block is idle (the block
  // does not enforce this); the front and back ends read these fields directly with no shadow copies.
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.center_x     <= RST_CENTER_X;
      cfg.center_y     <= RST_CENTER_Y;
      cfg.focal_x      <= RST_FOCAL_X;
      cfg.focal_y      <= RST_FOCAL_Y;
      cfg.depth_scale  <= RST_DEPTH_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[12:0];
        CFG_CENTER_X:     cfg.center_x     <= cfg_data;
        CFG_CENTER_Y:     cfg.center_y     <= cfg_data;
        CFG_FOCAL_X:      cfg.focal_x      <= cfg_data;
        CFG_FOCAL_Y:      cfg.focal_y      <= cfg_data;
        CFG_DEPTH_SCALE:  cfg.depth_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end tracks the raster position of every transfer and decides
  // whether it yields a result; only those pixels enter the queue.
  item_t   push_item, head;
  logic    push, pop, q_full, q_empty;
  result_t res;

  dpbu_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_depth  (s_tdata[15:0]),
    .in_blue   (s_tdata[23:16]),
    .in_green  (s_tdata[31:24]),
    .in_red    (s_tdata[39:32]),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // The queue lets the front end keep taking pixels while the back end divides.
  dpbu_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The back end works on one item at a time and holds its result in an output
  // register, so it can fetch the next item while the result waits.
  dpbu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {7'b0, res.point_count, res.out_red, res.out_green, res.out_blue,
                    res.pos_z, res.pos_y, res.pos_x};
  assign m_tuser = res.has_point;
  assign m_tlast = res.frame_end;

  // A result without a point is only ever a frame-end marker.
  `DPBU_ASSERT_IMP(a_nopoint_is_frame_end, m_tvalid && !m_tuser[0], m_tlast, "point-free result without frame end")
  // The point count travels on the frame-end result alone.
  `DPBU_ASSERT_IMP(a_count_only_at_end, m_tvalid && !m_tlast, m_tdata[160:136] == 25'd0, "point count outside frame end")
  // A nonzero depth over a 16-bit scale always gives a nonzero distance.
  `DPBU_ASSERT_IMP(a_point_has_depth, m_tvalid && m_tuser[0], m_tdata[111:80] != 32'd0, "point with zero distance")
  // The queue can never report full and empty together.
  `DPBU_ASSERT_ALWAYS(a_queue_consistent, !(q_full && q_empty), "queue full and empty at once")

endmodule

`default_nettype wire

[sv/dpbu_front.sv]
// Front end: pixel acceptance, raster counters, point counting and offsets.
// Depends on dpbu_pkg; pushes classified pixels into the queue.
`default_nettype none

module dpbu_front import dpbu_pkg::*; #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_depth,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_red,
  input  wire logic        q_full,
  output logic             push,
  output item_t            push_item
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [24:0]   emitted;

  logic [12:0] wc, hc;
  logic        row_end, frame_end, has, accept;
  logic [24:0] count_next;
  logic [16:0] px16, py16, cx17, cy17, dx, dy;
  logic        dx_neg, dy_neg;

  always_comb begin
    if (cfg.image_width == 13'd0) begin
      wc = 13'd1;
    end else if (cfg.image_width > 13'(MAX_COLS)) begin
      wc = 13'(MAX_COLS);
    end else begin
      wc = cfg.image_width;
    end
    if (cfg.image_height == 13'd0) begin
      hc = 13'd1;
    end else if (cfg.image_height > 13'(MAX_ROWS)) begin
      hc = 13'(MAX_ROWS);
    end else begin
      hc = cfg.image_height;
    end
  end

  assign row_end    = 13'(col) >= (wc - 13'd1);
  assign frame_end  = row_end && (13'(row) >= (hc - 13'd1));
  assign has        = in_depth != 16'd0;
  assign count_next = emitted + 25'(has);

  // Signed offsets from the principal point, as sign and magnitude.
  assign px16   = 17'({col, 4'b0000});
  assign py16   = 17'({row, 4'b0000});
  assign cx17   = {1'b0, cfg.center_x};
  assign cy17   = {1'b0, cfg.center_y};
  assign dx_neg = cx17 > px16;
  assign dy_neg = cy17 > py16;
  assign dx     = dx_neg ? (cx17 - px16) : (px16 - cx17);
  assign dy     = dy_neg ? (cy17 - py16) : (py16 - cy17);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (has || frame_end);

  always_comb begin
    push_item             = '0;
    push_item.depth       = in_depth;
    push_item.blue        = in_blue;
    push_item.green       = in_green;
    push_item.red         = in_red;
    push_item.dx_mag      = dx[15:0];
    push_item.dx_neg      = dx_neg;
    push_item.dy_mag      = dy[15:0];
    push_item.dy_neg      = dy_neg;
    push_item.has_point   = has;
    push_item.frame_end   = frame_end;
    push_item.point_count = frame_end ? count_next : 25'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      emitted <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col     <= '0;
        row     <= '0;
        emitted <= '0;
      end else if (row_end) begin
        col     <= '0;
        row     <= row + 1'b1;
        emitted <= count_next;
      end else begin
        col     <= col + 1'b1;
        emitted <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

[sv/dpbu_queue.sv]
// Short queue of classified pixels between the front and back ends.
// Depends on dpbu_pkg for the entry type.
`default_nettype none

module dpbu_queue import dpbu_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       full,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic          do_push, do_pop;

  assign full    = count == NW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[sv/dpbu_div.sv]
// Restoring divider, one quotient bit per cycle, DIV_W quotient bits per division.
// Depends on dpbu_pkg; shared by the three divisions of the back end.
`default_nettype none

module dpbu_div import dpbu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [15:0]      divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [15:0]       rem;
  logic [15:0]       dvs;
  logic [DIV_W-1:0]  quo;
  logic [16:0]       trial, diff;
  logic              ge;

  assign trial    = {rem, quo[DIV_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[15:0] : trial[15:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[sv/dpbu_back.sv]
// Back end: sequencer; computes z, x and y of a depth pixel and holds the result.
// Depends on dpbu_pkg and dpbu_div; reads items from the queue.
`default_nettype none

module dpbu_back import dpbu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire item_t head,
  input  wire logic  q_empty,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_res
);

  back_state_t      state, state_next;
  item_t            cur;
  logic [31:0]      z;
  logic [39:0]      xq, yq;

  logic             div_start, div_done, load_out;
  logic [DIV_W-1:0] div_dividend, div_quotient;
  logic [15:0]      div_divisor;
  logic [15:0]      mul_a;
  logic [DIV_W-1:0] prod;
  logic [15:0]      scale_eff, fx_eff, fy_eff;

  assign scale_eff = (cfg.depth_scale == 16'd0) ? 16'd1 : cfg.depth_scale;
  assign fx_eff    = (cfg.focal_x == 16'd0) ? 16'd1 : cfg.focal_x;
  assign fy_eff    = (cfg.focal_y == 16'd0) ? 16'd1 : cfg.focal_y;

  // One 16 x 32 multiplier, shared by x and y; the divider registers its output.
  assign mul_a = (state == BK_YMUL) ? cur.dy_mag : cur.dx_mag;
  assign prod  = DIV_W'(mul_a) * DIV_W'(z);

  dpbu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = head.has_point ? BK_ZDIV : BK_DONE;
        end
      end
      BK_ZDIV: begin
        if (div_done) begin
          state_next = BK_XMUL;
        end
      end
      BK_XMUL: state_next = BK_XDIV;
      BK_XDIV: begin
        if (div_done) begin
          state_next = BK_YMUL;
        end
      end
      BK_YMUL: state_next = BK_YDIV;
      BK_YDIV: begin
        if (div_done) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    div_dividend = prod;
    div_divisor  = fx_eff;
    case (state)
      BK_IDLE: begin
        pop          = !q_empty;
        div_start    = !q_empty && head.has_point;
        div_dividend = DIV_W'({head.depth, 16'h0000});
        div_divisor  = scale_eff;
      end
      BK_XMUL: begin
        div_start   = 1'b1;
        div_divisor = fx_eff;
      end
      BK_YMUL: begin
        div_start   = 1'b1;
        div_divisor = fy_eff;
      end
      BK_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == BK_ZDIV && div_done) begin
      z <= div_quotient[31:0];
    end
    if (state == BK_XDIV && div_done) begin
      xq <= sat_coord(div_quotient, cur.dx_neg);
    end
    if (state == BK_YDIV && div_done) begin
      yq <= sat_coord(div_quotient, cur.dy_neg);
    end
    if (load_out) begin
      out_res             <= '0;
      out_res.has_point   <= cur.has_point;
      out_res.frame_end   <= cur.frame_end;
      out_res.point_count <= cur.point_count;
      if (cur.has_point) begin
        out_res.pos_x     <= xq;
        out_res.pos_y     <= yq;
        out_res.pos_z     <= z;
        out_res.out_blue  <= cur.blue;
        out_res.out_green <= cur.green;
        out_res.out_red   <= cur.red;
      end
    end
  end

endmodule

`default_nettype wire
